/* design/polygon_rotate_scale_translate_core_assert.svh */
// Assertion macros for the polygon rotate/scale/translate checker.
`ifndef POLYGON_ROTATE_SCALE_TRANSLATE_CORE_ASSERT_SVH
`define POLYGON_ROTATE_SCALE_TRANSLATE_CORE_ASSERT_SVH

// Next-cycle implication, ignored while reset is high.
`define PRST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define PRST_ASSERT_ALWAYS_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

/* design/prst_pkg.sv */
// Shared constants, types and trig functions for the polygon transform core.
`default_nettype none

package prst_pkg;

  localparam int ANGLE_BITS = 10;
  localparam int COORD_BITS = 12;
  localparam int QBITS      = ANGLE_BITS - 2;
  localparam int QUARTER    = 1 << QBITS;

  localparam int MODEL_W  = 7;                 // model vertex coordinate
  localparam int SCALE_W  = 3;
  localparam int ORIGIN_W = 10;
  localparam int CFG_W    = 10;                // widest register
  localparam int SIN_W    = 16;                // signed Q1.15, +-32767
  localparam int ACC_W    = MODEL_W + SIN_W + 1;
  localparam int ROT_W    = ACC_W - 15 + 1;    // rotated coordinate
  localparam int PROD_W   = ROT_W + SIN_W;
  localparam int SUM_W    = PROD_W + 1;

  localparam int COORD_MIN = -(1 << (COORD_BITS - 1));
  localparam int COORD_MAX = (1 << (COORD_BITS - 1)) - 1;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [1:0] {
    REG_ANGLE    = 2'd0,
    REG_SCALE    = 2'd1,
    REG_ORIGIN_X = 2'd2,
    REG_ORIGIN_Y = 2'd3
  } cfg_reg_t;

  typedef logic [SIN_W-2:0] sine_rom_t [QUARTER];

  // round(32767*sin(k*pi/2/QUARTER)), Taylor series in Q30; elaboration only.
  function automatic logic [SIN_W-2:0] quarter_sine(int k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] r;
    longint      sum;
    x    = (64'(k) * HALF_PI_Q30 + (64'd1 << (QBITS - 1))) >> QBITS;
    x2   = (x * x) >> 30;
    sum  = longint'(x);
    term = x;
    for (int n = 1; n <= 9; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if ((n % 2) == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    r = (64'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
    if (r > 64'd32767) begin
      r = 64'd32767;
    end
    return r[SIN_W-2:0];
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    for (int k = 0; k < QUARTER; k++) begin
      rom[k] = quarter_sine(k);
    end
    return rom;
  endfunction

  // Index QUARTER (sin = 1) is not stored; it is the full-scale value.
  localparam sine_rom_t SINE_ROM = build_sine_rom();

  // Signed Q1.15 sine of a binary angle, quadrant folded onto the table.
  function automatic logic signed [SIN_W-1:0] sine_q15(logic [ANGLE_BITS-1:0] a);
    logic [1:0]       quad;
    logic [QBITS-1:0] k;
    logic [QBITS:0]   idx;
    logic [SIN_W-2:0] mag;
    logic [SIN_W-1:0] v;
    quad = a[ANGLE_BITS-1:QBITS];
    k    = a[QBITS-1:0];
    idx  = quad[0] ? ((QBITS + 1)'(QUARTER) - {1'b0, k}) : {1'b0, k};
    mag  = idx[QBITS] ? {(SIN_W - 1){1'b1}} : SINE_ROM[idx[QBITS-1:0]];
    v    = {1'b0, mag};
    if (quad[1]) begin
      v = -v;
    end
    return $signed(v);
  endfunction

  // Drop 15 fraction bits, rounding half away from zero.
  function automatic logic signed [ROT_W-1:0] round_q15(logic signed [ACC_W-1:0] v);
    logic [ACC_W-1:0] mag;
    logic [ACC_W-1:0] biased;
    logic [ROT_W-1:0] r;
    mag    = v[ACC_W-1] ? $unsigned(-v) : $unsigned(v);
    biased = mag + ACC_W'(1 << 14);
    r      = {1'b0, biased[ACC_W-1:15]};
    if (v[ACC_W-1]) begin
      r = -r;
    end
    return $signed(r);
  endfunction

  // Clamp to the signed coordinate range.
  function automatic logic signed [COORD_BITS-1:0] sat_coord(logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] c;
    c = v;
    if (v < COORD_MIN) begin
      c = SUM_W'(COORD_MIN);
    end else if (v > COORD_MAX) begin
      c = SUM_W'(COORD_MAX);
    end
    return c[COORD_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

/* design/prst_trig.sv */
// Sine/cosine lookup for the configured angle, registered when a word is taken.
`default_nettype none

module prst_trig (
  input  wire logic                                   clk,
  input  wire logic                                   load,
  input  wire logic [prst_pkg::ANGLE_BITS-1:0]        angle,
  output logic signed [prst_pkg::SIN_W-1:0]           sin_q,
  output logic signed [prst_pkg::SIN_W-1:0]           cos_q
);

  logic [prst_pkg::ANGLE_BITS-1:0] cos_angle;

  // cos(a) = sin(a + quarter turn)
  assign cos_angle = angle + prst_pkg::ANGLE_BITS'(prst_pkg::QUARTER);

  always_ff @(posedge clk) begin
    if (load) begin
      sin_q <= prst_pkg::sine_q15(angle);
      cos_q <= prst_pkg::sine_q15(cos_angle);
    end
  end

endmodule

`default_nettype wire

/* design/polygon_rotate_scale_translate_core.sv */
// Top level of the polygon rotate/scale/translate edge generator.
`default_nettype none

// Polygon vertices come in one word at a time on the vertex channel (model_x,
// model_y, last_vertex). Each is rotated by cfg angle (1024 units per turn,
// Q1.15 sin/cos from a quarter-wave ROM, rounded half away from zero), times
// the integer scale, plus the origin, clamped to 12-bit signed. From the
// second vertex on, one edge word (previous point -> current point) goes
// out; a vertex flagged last also sends the closing edge back to the first
// point with last_segment set, then the next vertex opens a new polygon.
// A lone vertex flagged last gives one zero-length closing edge.
// Timing: one 10x16 signed multiplier is shared by the four rotation
// products and the two scale products, one per cycle, so a vertex is taken,
// then vertex_stall stays high through six multiply steps and one
// bookkeeping step plus one step per edge word it produces (longer if the
// edge channel stalls). The next vertex may be taken while the last edge
// word still waits on the edge channel.
// Config: write cfg_index/cfg_data with cfg_write high, only while idle.
// Index 0 angle, 1 scale, 2 origin_x, 3 origin_y. Reset: angle 0, scale 1.

module polygon_rotate_scale_translate_core (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  // configuration write port
  input  wire logic                                  cfg_write,
  input  wire logic [1:0]                            cfg_index,
  input  wire logic [prst_pkg::CFG_W-1:0]            cfg_data,
  // vertex channel
  input  wire logic                                  vertex_valid,
  output logic                                       vertex_stall,
  input  wire logic signed [prst_pkg::MODEL_W-1:0]   model_x,
  input  wire logic signed [prst_pkg::MODEL_W-1:0]   model_y,
  input  wire logic                                  last_vertex,
  // edge channel
  output logic                                       edge_valid,
  input  wire logic                                  edge_stall,
  output logic signed [prst_pkg::COORD_BITS-1:0]     start_x,
  output logic signed [prst_pkg::COORD_BITS-1:0]     start_y,
  output logic signed [prst_pkg::COORD_BITS-1:0]     end_x,
  output logic signed [prst_pkg::COORD_BITS-1:0]     end_y,
  output logic                                       last_segment
);

  // Sequencer: one multiply per step, the accumulator collects x*c - y*s
  // and x*s + y*c, then each rotated value is scaled and offset.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MXC,     // acc  = mx*cos
    ST_MYS,     // acc -= my*sin
    ST_MXS,     // rx = round(acc), acc = mx*sin
    ST_MYC,     // acc += my*cos
    ST_SCX,     // ry = round(acc), tx = rx*scale + origin_x
    ST_SCY,     // ty = ry*scale + origin_y
    ST_FINISH,  // first vertex bookkeeping / pick edges
    ST_EDGE,    // send previous -> current
    ST_CLOSE    // send current -> first, last_segment
  } state_t;

  state_t state;

  // configuration
  logic [prst_pkg::ANGLE_BITS-1:0]        cfg_angle;
  logic [prst_pkg::SCALE_W-1:0]           cfg_scale;
  logic [prst_pkg::ORIGIN_W-1:0]          cfg_origin_x;
  logic [prst_pkg::ORIGIN_W-1:0]          cfg_origin_y;

  // vertex under work
  logic signed [prst_pkg::MODEL_W-1:0]    mx;
  logic signed [prst_pkg::MODEL_W-1:0]    my;
  logic                                   last_flag;
  logic signed [prst_pkg::SIN_W-1:0]      sin_q;
  logic signed [prst_pkg::SIN_W-1:0]      cos_q;
  logic signed [prst_pkg::ACC_W-1:0]      acc;
  logic signed [prst_pkg::ROT_W-1:0]      rx;
  logic signed [prst_pkg::ROT_W-1:0]      ry;
  logic signed [prst_pkg::COORD_BITS-1:0] tx;
  logic signed [prst_pkg::COORD_BITS-1:0] ty;

  // polygon state
  logic signed [prst_pkg::COORD_BITS-1:0] first_x;
  logic signed [prst_pkg::COORD_BITS-1:0] first_y;
  logic signed [prst_pkg::COORD_BITS-1:0] prev_x;
  logic signed [prst_pkg::COORD_BITS-1:0] prev_y;
  logic                                   have_first;

  // shared multiplier
  logic signed [prst_pkg::ROT_W-1:0]      mul_a;
  logic signed [prst_pkg::SIN_W-1:0]      mul_b;
  logic signed [prst_pkg::PROD_W-1:0]     product;
  logic signed [prst_pkg::ACC_W-1:0]      prod_acc;
  logic signed [prst_pkg::SUM_W-1:0]      prod_ext;
  logic signed [prst_pkg::SUM_W-1:0]      sum_x;
  logic signed [prst_pkg::SUM_W-1:0]      sum_y;
  logic signed [prst_pkg::ROT_W-1:0]      mx_ext;
  logic signed [prst_pkg::ROT_W-1:0]      my_ext;
  logic signed [prst_pkg::SIN_W-1:0]      scale_ext;

  logic vertex_accept;
  logic out_free;
  logic edge_load;

  assign vertex_stall  = (state != ST_IDLE);
  assign vertex_accept = vertex_valid && !vertex_stall;
  // edge register can take a new word this cycle
  assign out_free      = !edge_valid || !edge_stall;
  // a new edge word goes into the output register at this edge
  assign edge_load     = out_free && (state == ST_EDGE || state == ST_CLOSE);

  prst_trig u_trig (
    .clk   (clk),
    .load  (vertex_accept),
    .angle (cfg_angle),
    .sin_q (sin_q),
    .cos_q (cos_q)
  );

  assign mx_ext    = {{(prst_pkg::ROT_W - prst_pkg::MODEL_W){mx[prst_pkg::MODEL_W-1]}}, mx};
  assign my_ext    = {{(prst_pkg::ROT_W - prst_pkg::MODEL_W){my[prst_pkg::MODEL_W-1]}}, my};
  assign scale_ext = $signed({{(prst_pkg::SIN_W - prst_pkg::SCALE_W){1'b0}}, cfg_scale});

  always_comb begin
    unique case (state)
      ST_MXC: begin
        mul_a = mx_ext;
        mul_b = cos_q;
      end
      ST_MYS: begin
        mul_a = my_ext;
        mul_b = sin_q;
      end
      ST_MXS: begin
        mul_a = mx_ext;
        mul_b = sin_q;
      end
      ST_MYC: begin
        mul_a = my_ext;
        mul_b = cos_q;
      end
      ST_SCX: begin
        mul_a = rx;
        mul_b = scale_ext;
      end
      ST_SCY: begin
        mul_a = ry;
        mul_b = scale_ext;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign product  = mul_a * mul_b;
  // rotation products always fit the accumulator width
  assign prod_acc = product[prst_pkg::ACC_W-1:0];
  assign prod_ext = {product[prst_pkg::PROD_W-1], product};
  assign sum_x    = prod_ext
                  + $signed({{(prst_pkg::SUM_W - prst_pkg::ORIGIN_W){1'b0}}, cfg_origin_x});
  assign sum_y    = prod_ext
                  + $signed({{(prst_pkg::SUM_W - prst_pkg::ORIGIN_W){1'b0}}, cfg_origin_y});

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_angle    <= '0;
      cfg_scale    <= prst_pkg::SCALE_W'(1);
      cfg_origin_x <= '0;
      cfg_origin_y <= '0;
    end else if (cfg_write) begin
      unique case (prst_pkg::cfg_reg_t'(cfg_index))
        prst_pkg::REG_ANGLE:    cfg_angle    <= cfg_data[prst_pkg::ANGLE_BITS-1:0];
        prst_pkg::REG_SCALE:    cfg_scale    <= cfg_data[prst_pkg::SCALE_W-1:0];
        prst_pkg::REG_ORIGIN_X: cfg_origin_x <= cfg_data[prst_pkg::ORIGIN_W-1:0];
        prst_pkg::REG_ORIGIN_Y: cfg_origin_y <= cfg_data[prst_pkg::ORIGIN_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer, datapath and edge output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      have_first <= 1'b0;
      edge_valid <= 1'b0;
      first_x    <= '0;
      first_y    <= '0;
      prev_x     <= '0;
      prev_y     <= '0;
    end else begin
      if (edge_load) begin
        edge_valid <= 1'b1;
      end else if (!edge_stall) begin
        edge_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (vertex_accept) begin
            mx        <= model_x;
            my        <= model_y;
            last_flag <= last_vertex;
            state     <= ST_MXC;
          end
        end
        ST_MXC: begin
          acc   <= prod_acc;
          state <= ST_MYS;
        end
        ST_MYS: begin
          acc   <= acc - prod_acc;
          state <= ST_MXS;
        end
        ST_MXS: begin
          rx    <= prst_pkg::round_q15(acc);
          acc   <= prod_acc;
          state <= ST_MYC;
        end
        ST_MYC: begin
          acc   <= acc + prod_acc;
          state <= ST_SCX;
        end
        ST_SCX: begin
          ry    <= prst_pkg::round_q15(acc);
          tx    <= prst_pkg::sat_coord(sum_x);
          state <= ST_SCY;
        end
        ST_SCY: begin
          ty    <= prst_pkg::sat_coord(sum_y);
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (!have_first) begin
            first_x    <= tx;
            first_y    <= ty;
            prev_x     <= tx;
            prev_y     <= ty;
            have_first <= 1'b1;
            state      <= last_flag ? ST_CLOSE : ST_IDLE;
          end else begin
            state <= ST_EDGE;
          end
        end
        ST_EDGE: begin
          if (out_free) begin
            start_x      <= prev_x;
            start_y      <= prev_y;
            end_x        <= tx;
            end_y        <= ty;
            last_segment <= 1'b0;
            prev_x       <= tx;
            prev_y       <= ty;
            state        <= last_flag ? ST_CLOSE : ST_IDLE;
          end
        end
        ST_CLOSE: begin
          // first_x/y already hold this point for a lone vertex
          if (out_free) begin
            start_x      <= tx;
            start_y      <= ty;
            end_x        <= first_x;
            end_y        <= first_y;
            last_segment <= 1'b1;
            have_first   <= 1'b0;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* design/prst_checker.sv */
// Port-level checks for the polygon transform core, bound to the top level.
`default_nettype none

`include "polygon_rotate_scale_translate_core_assert.svh"

module prst_checker (
  input wire logic                                  clk,
  input wire logic                                  rst,
  input wire logic                                  vertex_valid,
  input wire logic                                  vertex_stall,
  input wire logic                                  edge_valid,
  input wire logic                                  edge_stall,
  input wire logic signed [prst_pkg::COORD_BITS-1:0] start_x,
  input wire logic signed [prst_pkg::COORD_BITS-1:0] start_y,
  input wire logic signed [prst_pkg::COORD_BITS-1:0] end_x,
  input wire logic signed [prst_pkg::COORD_BITS-1:0] end_y,
  input wire logic                                  last_segment
);

  // a taken vertex keeps the core busy while it is worked
  `PRST_ASSERT_NEXT(a_busy_after_vertex, vertex_valid && !vertex_stall, vertex_stall, "core not busy after vertex")

  // an edge word never appears in the cycle right after a vertex is taken
  `PRST_ASSERT_NEXT(a_no_instant_edge, vertex_valid && !vertex_stall, !$rose(edge_valid), "edge word too early")

  // stalled edge word holds
  `PRST_ASSERT_NEXT(a_edge_hold, edge_valid && edge_stall, edge_valid && $stable(start_x) && $stable(start_y) && $stable(end_x) && $stable(end_y) && $stable(last_segment), "stalled edge word changed")

  // reset leaves no edge word pending
  `PRST_ASSERT_ALWAYS_NEXT(a_reset_clears, rst, !edge_valid, "edge valid after reset")

endmodule

bind polygon_rotate_scale_translate_core prst_checker u_prst_checker (.*);

`default_nettype wire

/* dv/tb.sv */
// Self-checking testbench for the polygon rotate/scale/translate edge generator.
`timescale 1ns / 1ps

module tb;

  // Cycles without any word moving on either channel before the run is
  // declared hung.
  localparam int HANG_LIMIT = 2000;
  // Settle time after the last edge word before touching config or ending.
  localparam int TAIL_CYCLES = 16;
  // pi/2 in Q30, seed of the sine series
  localparam logic [63:0] QTR_TURN_Q30 = 64'd1686629713;

  typedef struct packed {
    logic signed [6:0] x;
    logic signed [6:0] y;
    logic              last;
  } vertex_t;

  typedef struct packed {
    logic signed [11:0] sx;
    logic signed [11:0] sy;
    logic signed [11:0] ex;
    logic signed [11:0] ey;
    logic               closing;
  } seg_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                           cfg_write = 1'b0;
  prst_pkg::cfg_reg_t             cfg_index = prst_pkg::REG_ANGLE;
  logic [prst_pkg::CFG_W-1:0]     cfg_data  = '0;

  logic                    vertex_valid = 1'b0;
  logic                    vertex_stall;
  logic signed [6:0]       model_x = '0;
  logic signed [6:0]       model_y = '0;
  logic                    last_vertex = 1'b0;

  logic                    edge_valid;
  logic                    edge_stall = 1'b0;
  logic signed [11:0]      start_x;
  logic signed [11:0]      start_y;
  logic signed [11:0]      end_x;
  logic signed [11:0]      end_y;
  logic                    last_segment;

  polygon_rotate_scale_translate_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .vertex_valid (vertex_valid),
    .vertex_stall (vertex_stall),
    .model_x      (model_x),
    .model_y      (model_y),
    .last_vertex  (last_vertex),
    .edge_valid   (edge_valid),
    .edge_stall   (edge_stall),
    .start_x      (start_x),
    .start_y      (start_y),
    .end_x        (end_x),
    .end_y        (end_y),
    .last_segment (last_segment)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor: its own copy of the register file and polygon state.
  // ---------------------------------------------------------------------------
  int          sine_lut [0:256];   // quarter wave, index 256 = full scale
  logic [9:0]  rot_angle = '0;
  int          zoom      = 1;
  int          shift_x   = 0;
  int          shift_y   = 0;

  logic signed [11:0] poly_first_x = '0;
  logic signed [11:0] poly_first_y = '0;
  logic signed [11:0] poly_prev_x  = '0;
  logic signed [11:0] poly_prev_y  = '0;
  logic               poly_open    = 1'b0;

  vertex_t pending_vertices [$];   // words not yet offered to the block
  seg_t    expected_edges   [$];   // edges the block still owes us
  int      mismatches = 0;
  logic    calm = 1'b0;            // no idling on either side while set
  bit      vertex_taken = 1'b0;    // set at the edge a vertex word moves
  vertex_t next_vtx;
  int      idle_cycles = 0;

  // round(32767*sin(k*pi/512)) with integer math: odd Taylor series in Q30,
  // the way the ROM contents are built.
  function automatic int quarter_wave(int k);
    logic [63:0] ang;
    logic [63:0] ang_sq;
    logic [63:0] term;
    logic [63:0] scaled;
    longint      acc;
    ang    = k;
    ang    = (ang * QTR_TURN_Q30 + 64'd128) >> 8;
    ang_sq = (ang * ang) >> 30;
    acc    = longint'(ang);
    term   = ang;
    for (int n = 1; n <= 9; n++) begin
      term = ((term * ang_sq) >> 30) / ((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    scaled = acc;
    scaled = (scaled * 64'd32767 + (64'd1 << 29)) >> 30;
    if (scaled > 64'd32767) begin
      scaled = 64'd32767;
    end
    return int'(scaled);
  endfunction

  // Full-circle Q1.15 sine: fold the quadrant onto the quarter table.
  function automatic int sine_of(logic [9:0] a);
    int idx;
    int mag;
    idx = a[7:0];
    if (a[8]) begin
      idx = 256 - idx;
    end
    mag = sine_lut[idx];
    return a[9] ? -mag : mag;
  endfunction

  // Drop the Q15 fraction, ties away from zero.
  function automatic int drop_q15(int v);
    int mag;
    mag = (v < 0) ? -v : v;
    mag = (mag + 16384) >> 15;
    return (v < 0) ? -mag : mag;
  endfunction

  // Scale, translate and clamp to the 12-bit signed coordinate range.
  function automatic logic signed [11:0] place(int rot, int org);
    int v;
    v = rot * zoom + org;
    if (v < -2048) begin
      v = -2048;
    end else if (v > 2047) begin
      v = 2047;
    end
    return v[11:0];
  endfunction

  // Append one edge word to the expected list.
  task automatic expect_edge(logic signed [11:0] sx, logic signed [11:0] sy,
                             logic signed [11:0] ex, logic signed [11:0] ey,
                             logic closing);
    seg_t s;
    s.sx           = sx;
    s.sy           = sy;
    s.ex           = ex;
    s.ey           = ey;
    s.closing      = closing;
    expected_edges = {expected_edges, s};
  endtask

  // Transform one accepted vertex and queue the edge words it causes.
  task automatic predict_edges(int mx, int my, logic last);
    int                 sn;
    int                 cs;
    logic signed [11:0] tx;
    logic signed [11:0] ty;
    sn = sine_of(rot_angle);
    cs = sine_of(rot_angle + 10'd256);
    tx = place(drop_q15(mx * cs - my * sn), shift_x);
    ty = place(drop_q15(mx * sn + my * cs), shift_y);
    if (!poly_open) begin
      poly_first_x = tx;
      poly_first_y = ty;
      poly_open    = 1'b1;
    end else begin
      expect_edge(poly_prev_x, poly_prev_y, tx, ty, 1'b0);
    end
    poly_prev_x = tx;
    poly_prev_y = ty;
    if (last) begin
      // closing edge back to the opening point; a lone vertex closes on itself
      expect_edge(tx, ty, poly_first_x, poly_first_y, 1'b1);
      poly_open = 1'b0;
    end
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Vertex driver: payload changes on the falling edge, only once the word on
  // the port has moved (or none was up). Valid never looks at stall.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      vertex_valid <= 1'b0;
    end else if (!vertex_valid || vertex_taken) begin
      vertex_taken = 1'b0;
      if (pending_vertices.size() != 0 && (calm || $urandom_range(99) >= 24)) begin
        next_vtx = pending_vertices.pop_front();
        model_x      <= next_vtx.x;
        model_y      <= next_vtx.y;
        last_vertex  <= next_vtx.last;
        vertex_valid <= 1'b1;
      end else begin
        vertex_valid <= 1'b0;
      end
    end
  end

  // Vertex handshake seen at the rising edge feeds the predictor.
  always @(posedge clk) begin
    if (!rst && vertex_valid && !vertex_stall) begin
      vertex_taken = 1'b1;
      predict_edges(model_x, model_y, last_vertex);
    end
  end

  // Edge receiver back-pressure, random outside the calm stretch.
  always @(negedge clk) begin
    edge_stall <= !calm && ($urandom_range(99) < 24);
  end

  // ---------------------------------------------------------------------------
  // Edge monitor: every word that moves is matched against the oldest
  // prediction, field by field.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    seg_t want;
    if (!rst && edge_valid && !edge_stall) begin
      if (expected_edges.size() == 0) begin
        $display("%0t: unexpected edge word, expected none, got (%0d,%0d)->(%0d,%0d) last %0b",
                 $time, start_x, start_y, end_x, end_y, last_segment);
        mismatches++;
      end else begin
        want = expected_edges.pop_front();
        check_field("start_x", want.sx, start_x);
        check_field("start_y", want.sy, start_y);
        check_field("end_x", want.ex, end_x);
        check_field("end_y", want.ey, end_y);
        check_field("last_segment", want.closing, last_segment);
      end
    end
  end

  // Hang detector: nothing moving on either channel for too long.
  always @(posedge clk) begin
    if ((vertex_valid && !vertex_stall) || (edge_valid && !edge_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == HANG_LIMIT) begin
        $display("tb: FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_vertex(int x, int y, logic last);
    vertex_t v;
    v.x    = x[6:0];
    v.y    = y[6:0];
    v.last = last;
    pending_vertices = {pending_vertices, v};
  endtask

  // Mostly uniform, with the range ends and zero crossing pulled in often.
  function automatic int pick_coord();
    int sel;
    sel = $urandom_range(9);
    case (sel)
      0: return -64;
      1: return 63;
      2: return $urandom_range(1) ? 0 : -1;
      default: return int'($urandom_range(127)) - 64;
    endcase
  endfunction

  // Hold until every offered word has moved and every edge has come out,
  // then let the block finish any vertex that owes no edge.
  task automatic wait_drained();
    while (pending_vertices.size() != 0 || vertex_valid || expected_edges.size() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(prst_pkg::cfg_reg_t idx, logic [prst_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      prst_pkg::REG_ANGLE:    rot_angle = val[9:0];
      prst_pkg::REG_SCALE:    zoom      = val[2:0];   // upper data bits are don't-care
      prst_pkg::REG_ORIGIN_X: shift_x   = val;
      prst_pkg::REG_ORIGIN_Y: shift_y   = val;
      default: ;
    endcase
  endtask

  task automatic write_settings(int ang, int scl, int ox, int oy);
    write_reg(prst_pkg::REG_ANGLE, ang[9:0]);
    write_reg(prst_pkg::REG_SCALE, scl[9:0]);
    write_reg(prst_pkg::REG_ORIGIN_X, ox[9:0]);
    write_reg(prst_pkg::REG_ORIGIN_Y, oy[9:0]);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int queued;
    int len;
    for (int k = 0; k <= 256; k++) begin
      sine_lut[k] = quarter_wave(k);
    end

    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // Reset settings: identity rotation, unit scale, no offset.
    push_vertex(63, -64, 1'b1);          // lone vertex: zero-length closing edge
    push_vertex(-64, -64, 1'b0);         // square on the coordinate extremes
    push_vertex(63, -64, 1'b0);
    push_vertex(63, 63, 1'b0);
    push_vertex(-64, 63, 1'b1);
    push_vertex(0, 0, 1'b1);
    wait_drained();

    // Quarter turn, max scale (junk in the unused data bits), max origin.
    write_settings(256, 10'h3FF, 1023, 1023);
    push_vertex(63, 63, 1'b0);
    push_vertex(-64, 0, 1'b0);
    push_vertex(0, -64, 1'b1);
    wait_drained();

    // Top angle code, zero scale: everything collapses onto the origin.
    write_settings(1023, 10'h3F8, 0, 0);
    push_vertex(-1, -1, 1'b0);
    push_vertex(1, 1, 1'b1);
    wait_drained();

    // Half and three-quarter turns, mixed origins.
    write_settings(512, 3, 512, 0);
    push_vertex(63, -64, 1'b0);
    push_vertex(-64, 63, 1'b0);
    push_vertex(40, -40, 1'b1);
    wait_drained();
    write_settings(768, 5, 0, 1023);
    push_vertex(-64, -64, 1'b0);
    push_vertex(63, 63, 1'b1);
    push_vertex(17, -33, 1'b1);          // back-to-back polygons
    wait_drained();

    // Random phases, each under its own settings; the block is drained
    // between them so registers only change while it is idle.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: write_settings(1023, 7, 1023, 1023);
        1: write_settings(0, 0, 0, 0);
        default: write_settings($urandom_range(1023), $urandom_range(1023),
                                $urandom_range(1023), $urandom_range(1023));
      endcase
      calm = (phase == 3);
      queued = 0;
      while (queued < 125) begin
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++) begin
          // occasional stray flag breaks a polygon early or leaves it open
          if ($urandom_range(9) == 0) begin
            push_vertex(pick_coord(), pick_coord(), $urandom_range(1));
          end else begin
            push_vertex(pick_coord(), pick_coord(), i == len - 1);
          end
        end
        queued += len;
      end
      wait_drained();
      calm = 1'b0;
    end

    if (mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
